// File: src/lvs_pkg.sv
// ----------------------------------------------------------------------------
// lvs_pkg
// Shared constants for the Laplacian-variance sharpness unit.
// ----------------------------------------------------------------------------
package lvs_pkg;

  // image size limits
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // register file
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_COLOR_MODE   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // pixel and gray formats
  localparam int CHAN_W = 8;
  localparam int GRAY_W = 16;
  localparam int LUMA_W = 25;
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;
  localparam logic [LUMA_W-1:0] LUMA_ROUND = 25'd128;

  // laplacian: signed 4-neighbour sum of 8.8 values, and its square
  localparam int LAP_W = GRAY_W + 3;
  localparam int SQR_W = 2 * (LAP_W - 1);

  // result
  localparam int SHARP_W = 40;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // shared multiplier of the end-of-frame sequencer
  localparam int MUL_W = 32;

endpackage

// File: src/lvs_ram.sv
// ----------------------------------------------------------------------------
// lvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/laplacian_variance_sharpness_unit.sv
// ----------------------------------------------------------------------------
// laplacian_variance_sharpness_unit
// Variance of the 3x3 four-neighbour Laplacian over one frame of pixels.
// ----------------------------------------------------------------------------
// Pixel flow: each pixel item is accepted, its line store is read, then the
//   window is updated and written back before the next pixel item is taken;
//   pixels stall while a frame result is computed. The result item is set by
//   the bit-serial restoring divider; a too-small frame skips the divider.
// Reset: synchronous, active high; registers return to 640x480 color mode,
//   counters and sums clear; the line stores need no clearing.
// ----------------------------------------------------------------------------
module laplacian_variance_sharpness_unit #(
  parameter int MAX_WIDTH  = lvs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lvs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  // pixel items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lvs_pkg::IN_DATA_W-1:0]   s_tdata,   // red[7:0], green[15:8], blue[23:16]
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lvs_pkg::OUT_DATA_W-1:0]  m_tdata,   // sharpness[39:0]
  output logic                            m_tuser,   // too_small[0]
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lvs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lvs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lvs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import lvs_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = ((CW > RW) ? CW : RW) + 1;
  localparam int N_W    = CW + RW;
  localparam int SUM_W  = LAP_W + N_W;
  localparam int SQ_W   = SQR_W + N_W;
  localparam int NSQ_W  = N_W + SQ_W;
  localparam int S2_W   = 2 * SUM_W;
  localparam int CMP_W  = (NSQ_W > S2_W) ? NSQ_W : S2_W;
  localparam int D_W    = 2 * N_W;
  localparam int ML     = (SUM_W + 1) / 2;
  localparam int CNT_W  = $clog2(NSQ_W);
  localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_UPD  = 13'b0000000000010,
    ST_N    = 13'b0000000000100,
    ST_N2   = 13'b0000000001000,
    ST_D    = 13'b0000000010000,
    ST_P1   = 13'b0000000100000,
    ST_P2   = 13'b0000001000000,
    ST_P3   = 13'b0000010000000,
    ST_P4   = 13'b0000100000000,
    ST_P5   = 13'b0001000000000,
    ST_SUB  = 13'b0010000000000,
    ST_DIV  = 13'b0100000000000,
    ST_OUT  = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [CFG_DIM_W-1:0] frame_width, frame_height;
  logic                 color_mode;
  logic                 cfg_wr, cfg_hit, restart;
  reg_index_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_index_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_hit = cfg_wr & (cfg_idx != REG_UNUSED);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      color_mode   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_DIM_W-1:0];
        REG_COLOR_MODE:   color_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height);
      REG_COLOR_MODE:   prdata = CFG_DATA_W'(color_mode);
      default:          prdata = '0;
    endcase
  end

  // clamped frame size
  logic [DIM_W-1:0] dim_w, dim_h, fw_ext, fh_ext;
  assign fw_ext = DIM_W'(frame_width);
  assign fh_ext = DIM_W'(frame_height);
  assign dim_w  = (fw_ext == '0) ? DIM_W'(1) : ((fw_ext > MAX_W_D) ? MAX_W_D : fw_ext);
  assign dim_h  = (fh_ext == '0) ? DIM_W'(1) : ((fh_ext > MAX_H_D) ? MAX_H_D : fh_ext);

  // gray conversion
  logic [LUMA_W-1:0]  luma;
  logic [GRAY_W-1:0]  gray_in;
  assign luma = LUMA_W'(W_RED) * LUMA_W'(s_tdata[7:0])
              + LUMA_W'(W_GREEN) * LUMA_W'(s_tdata[15:8])
              + LUMA_W'(W_BLUE) * LUMA_W'(s_tdata[23:16]) + LUMA_ROUND;
  assign gray_in = color_mode ? luma[23:8] : {s_tdata[7:0], 8'd0};

  logic s_acc;
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid & s_tready;

  // pixel position and current gray
  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [GRAY_W-1:0] cur;
  logic              last_col, last_row;
  assign last_col = !((DIM_W'(col) + DIM_W'(1)) < dim_w);
  assign last_row = !((DIM_W'(row) + DIM_W'(1)) < dim_h);

  // line stores
  logic [GRAY_W-1:0] top_rd, mid_rd;
  logic              ls_we;
  assign ls_we = (state == ST_UPD);

  lvs_ram #(.WIDTH(GRAY_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk(clk), .we(ls_we), .waddr(col), .wdata(cur), .raddr(col), .rdata(mid_rd)
  );

  lvs_ram #(.WIDTH(GRAY_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk(clk), .we(ls_we), .waddr(col), .wdata(mid_rd), .raddr(col), .rdata(top_rd)
  );

  // window columns: {top, mid, cur}; the newest column comes from the line store
  logic [3*GRAY_W-1:0] win1, win2;
  logic signed [LAP_W-1:0] lap;
  assign lap = $signed(LAP_W'(win2[3*GRAY_W-1:2*GRAY_W])) + $signed(LAP_W'(win2[GRAY_W-1:0]))
             + $signed(LAP_W'(win1[2*GRAY_W-1:GRAY_W])) + $signed(LAP_W'(mid_rd))
             - $signed({1'b0, win2[2*GRAY_W-1:GRAY_W], 2'b00});

  // accumulation pipeline
  logic signed [LAP_W-1:0] lap_r, lap_d;
  logic [LAP_W-2:0]        lap_mag;
  logic                    lap_v, lap_v2;
  logic [SQR_W-1:0]        sqr_r;
  logic signed [SUM_W-1:0] lap_sum;
  logic [SQ_W-1:0]         lap_sq_sum;
  logic                    res_load, out_load;

  assign restart = cfg_hit | res_load;
  assign lap_mag = lap_r[LAP_W-1] ? (LAP_W-1)'(-lap_r) : (LAP_W-1)'(lap_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      lap_v  <= 1'b0;
      lap_v2 <= 1'b0;
    end else begin
      lap_v  <= ls_we && (row >= RW'(2)) && (col >= CW'(2));
      lap_v2 <= lap_v;
    end
  end

  always_ff @(posedge clk) begin
    lap_r <= lap;
    lap_d <= lap_r;
    sqr_r <= SQR_W'(lap_mag) * SQR_W'(lap_mag);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      lap_sum    <= '0;
      lap_sq_sum <= '0;
    end else if (lap_v2) begin
      lap_sum    <= lap_sum + SUM_W'(lap_d);
      lap_sq_sum <= lap_sq_sum + SQ_W'(sqr_r);
    end
  end

  // end-of-frame sequencer datapath
  logic [2*MUL_W-1:0] prod;
  logic [MUL_W-1:0]   op_a, op_b;
  logic [N_W-1:0]     n_cnt, wm2, hm2;
  logic [D_W-1:0]     dvs;
  logic [SUM_W-1:0]   mag;
  logic [NSQ_W-1:0]   acc, num;
  logic [S2_W-1:0]    s2;
  logic [D_W-1:0]     rem;
  logic [D_W:0]       rem_sh;
  logic [SHARP_W-1:0] quot;
  logic               ovf, small_r;
  logic [CNT_W-1:0]   cnt;
  logic [CMP_W-1:0]   acc_x, s2_x, diff_x;

  assign wm2 = (dim_w >= DIM_W'(3)) ? N_W'(dim_w - DIM_W'(2)) : '0;
  assign hm2 = (dim_h >= DIM_W'(3)) ? N_W'(dim_h - DIM_W'(2)) : '0;
  assign acc_x  = CMP_W'(acc);
  assign s2_x   = CMP_W'(s2);
  assign diff_x = acc_x - s2_x;
  assign rem_sh = {rem, num[NSQ_W-1]};

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_N: begin
        op_a = MUL_W'(wm2);
        op_b = MUL_W'(hm2);
      end
      ST_N2: begin
        op_a = MUL_W'(prod[N_W-1:0]);
        op_b = MUL_W'(prod[N_W-1:0] - N_W'(1));
      end
      ST_D: begin
        op_a = MUL_W'(n_cnt);
        op_b = lap_sq_sum[MUL_W-1:0];
      end
      ST_P1: begin
        op_a = MUL_W'(n_cnt);
        op_b = MUL_W'(lap_sq_sum[SQ_W-1:MUL_W]);
      end
      ST_P2: begin
        op_a = MUL_W'(mag[ML-1:0]);
        op_b = MUL_W'(mag[ML-1:0]);
      end
      ST_P3: begin
        op_a = MUL_W'(mag[ML-1:0]);
        op_b = MUL_W'(mag[SUM_W-1:ML]);
      end
      ST_P4: begin
        op_a = MUL_W'(mag[SUM_W-1:ML]);
        op_b = MUL_W'(mag[SUM_W-1:ML]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // result register
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      res_load <= 1'b0;
    end else begin
      res_load <= out_load;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= ovf ? {OUT_DATA_W{1'b1}} : OUT_DATA_W'(quot);
      m_tuser <= small_r;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      col      <= '0;
      row      <= '0;
      win1     <= '0;
      win2     <= '0;
    end else begin
      if (cfg_hit) begin
        col  <= '0;
        row  <= '0;
        win1 <= '0;
        win2 <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            cur   <= gray_in;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          win1  <= win2;
          win2  <= {top_rd, mid_rd, cur};
          col   <= last_col ? '0 : col + CW'(1);
          if (last_col) begin
            row <= last_row ? '0 : row + RW'(1);
          end
          state <= (last_col && last_row) ? ST_N : ST_IDLE;
        end
        ST_N: state <= ST_N2;
        ST_N2: begin
          n_cnt <= prod[N_W-1:0];
          if (prod[N_W-1:0] < N_W'(2)) begin
            small_r <= 1'b1;
            ovf     <= 1'b0;
            quot    <= '0;
            state   <= ST_OUT;
          end else begin
            small_r <= 1'b0;
            state   <= ST_D;
          end
        end
        ST_D: begin
          dvs   <= D_W'(prod);
          state <= ST_P1;
        end
        ST_P1: begin
          acc   <= NSQ_W'(prod);
          mag   <= lap_sum[SUM_W-1] ? SUM_W'(-lap_sum) : SUM_W'(lap_sum);
          state <= ST_P2;
        end
        ST_P2: begin
          acc   <= acc + (NSQ_W'(prod) << MUL_W);
          state <= ST_P3;
        end
        ST_P3: begin
          s2    <= S2_W'(prod);
          state <= ST_P4;
        end
        ST_P4: begin
          s2    <= s2 + (S2_W'(prod) << (ML + 1));
          state <= ST_P5;
        end
        ST_P5: begin
          s2    <= s2 + (S2_W'(prod) << (2 * ML));
          state <= ST_SUB;
        end
        ST_SUB: begin
          num   <= (acc_x >= s2_x) ? NSQ_W'(diff_x) : '0;
          rem   <= '0;
          quot  <= '0;
          ovf   <= 1'b0;
          cnt   <= CNT_W'(NSQ_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          // one quotient bit per cycle
          num <= num << 1;
          if (rem_sh >= {1'b0, dvs}) begin
            rem  <= D_W'(rem_sh - {1'b0, dvs});
            quot <= {quot[SHARP_W-2:0], 1'b1};
          end else begin
            rem  <= D_W'(rem_sh);
            quot <= {quot[SHARP_W-2:0], 1'b0};
          end
          ovf <= ovf | quot[SHARP_W-1];
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            win1  <= '0;
            win2  <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
